>>> rtl/core/iprt_pkg.sv
// ----------------------------------------------------------------------------
// iprt_pkg: shared types and constants of the IPv4 route table
// Function codes, result codes, address classes, register indices, table geometry and the entry and result records.
// ----------------------------------------------------------------------------
package iprt_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int CntW       = $clog2(TableDepth + 1);

	localparam logic [31:0] LoopbackAddr = 32'h7F00_0001;
	localparam logic [31:0] AnyAddr      = 32'h0000_0000;

	localparam logic [1:0] FuncMatch  = 2'd0;
	localparam logic [1:0] FuncAdd    = 2'd1;
	localparam logic [1:0] FuncRemove = 2'd2;

	localparam logic [1:0] StatusOk   = 2'd0;
	localparam logic [1:0] StatusDup  = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;

	localparam logic [2:0] ClassUnknown = 3'd0;
	localparam logic [2:0] ClassAny     = 3'd1;
	localparam logic [2:0] ClassLoop    = 3'd2;
	localparam logic [2:0] ClassLocal   = 3'd3;
	localparam logic [2:0] ClassBcast   = 3'd4;
	localparam logic [2:0] ClassSubnet  = 3'd5;

	localparam logic [0:0] RegLoopEnable = 1'd0;
	localparam logic [0:0] RegLoopIface  = 1'd1;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] host;
		logic [31:0] gw;
		logic [31:0] bcast;
		logic [7:0]  prio;
		logic [5:0]  plen;
		logic [3:0]  port;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] addr_class;
		logic       hit;
		logic [3:0] iface;
		logic [31:0] host;
		logic [31:0] hop;
		logic [4:0] removed;
	} result_t;

endpackage

>>> rtl/core/iprt_popcount.sv
// ----------------------------------------------------------------------------
// iprt_popcount: serial population count
// Shifts the mask right one bit a cycle and counts the ones.
// ----------------------------------------------------------------------------
module iprt_popcount (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        done,
	output logic [5:0]  count
);

	logic [31:0] sh_q;
	logic [5:0]  cnt_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && sh_q == 32'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			cnt_q <= 6'd0;
		end else if (busy_q && sh_q != 32'd0) begin
			sh_q  <= sh_q >> 1;
			cnt_q <= cnt_q + {5'd0, sh_q[0]};
		end
	end

	assign done  = busy_q && sh_q == 32'd0;
	assign count = cnt_q;

endmodule

>>> rtl/core/ipv4_route_table_classify.sv
// ----------------------------------------------------------------------------
// ipv4_route_table_classify: ordered IPv4 route table
// Match, add and remove on a sixteen-entry priority-ordered route table.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; stall on the input is high from the
// transfer until the result has been taken. The entry memory has one read
// and one write port and a sequencer walks it one slot a cycle. An add runs
// a duplicate scan, a serial popcount of the mask, a position search, then a
// one-slot-a-cycle shift; a remove compacts the table in a single pass.
// Reset empties the table at once.
module ipv4_route_table_classify (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] dest_addr,
	input  logic [31:0] route_net,
	input  logic [31:0] route_mask,
	input  logic [31:0] route_host,
	input  logic [31:0] route_hop,
	input  logic [31:0] route_broad,
	input  logic [7:0]  route_prio,
	input  logic [3:0]  iface_id,
	input  logic [3:0]  compare_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  addr_class,
	output logic        hit,
	output logic [3:0]  out_iface,
	output logic [31:0] out_host,
	output logic [31:0] out_hop,
	output logic [4:0]  removed_count
);

	localparam int IdxW = iprt_pkg::IdxW;
	localparam int CntW = iprt_pkg::CntW;

	localparam logic [3:0] StIdle   = 4'd0;
	localparam logic [3:0] StMatch  = 4'd1;
	localparam logic [3:0] StDup    = 4'd2;
	localparam logic [3:0] StPop    = 4'd3;
	localparam logic [3:0] StPos    = 4'd4;
	localparam logic [3:0] StShift  = 4'd5;
	localparam logic [3:0] StInsert = 4'd6;
	localparam logic [3:0] StRemove = 4'd7;
	localparam logic [3:0] StDone   = 4'd8;
	localparam logic [3:0] StRdWait = 4'd9;

	// configuration
	logic       loop_en_q;
	logic [3:0] loop_if_q;
	logic       cfg_wr;
	logic [0:0] cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q <= 1'b0;
			loop_if_q <= 4'd0;
		end else if (cfg_wr && paddr[1:0] == 2'd0) begin
			unique case (cfg_idx)
				iprt_pkg::RegLoopEnable: loop_en_q <= pwdata[0];
				iprt_pkg::RegLoopIface:  loop_if_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'd0) begin
			unique case (cfg_idx)
				iprt_pkg::RegLoopEnable: prdata = {31'd0, loop_en_q};
				iprt_pkg::RegLoopIface:  prdata = {28'd0, loop_if_q};
				default: prdata = 32'd0;
			endcase
		end
	end

	// entry memory: one write and one registered read a cycle
	iprt_pkg::entry_t mem [iprt_pkg::TableDepth];
	iprt_pkg::entry_t rd_s1;
	logic [IdxW-1:0]  rd_addr;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	iprt_pkg::entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	// operation registers
	logic [3:0]       state_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  idx_q;     // slot whose data sits in rd_s1
	logic [CntW-1:0]  wp_q;      // remove write pointer / insert position
	logic [1:0]       func_q;
	logic [31:0]      dst_q;
	iprt_pkg::entry_t new_q;
	logic [3:0]       sel_q;
	iprt_pkg::result_t res_q;

	logic        pc_start;
	logic        pc_done;
	logic [5:0]  pc_count;

	iprt_popcount u_popcount (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pc_start),
		.value  (new_q.mask),
		.done   (pc_done),
		.count  (pc_count)
	);

	logic filt;
	logic at_end;
	logic ins_before;

	assign filt = (!sel_q[0] || rd_s1.port == new_q.port)
		&& (!sel_q[1] || rd_s1.net == new_q.net)
		&& (!sel_q[2] || rd_s1.host == new_q.host)
		&& (!sel_q[3] || rd_s1.gw == new_q.gw);
	assign at_end = idx_q >= count_q;
	assign ins_before = new_q.prio > rd_s1.prio
		|| (new_q.prio == rd_s1.prio && new_q.plen >= rd_s1.plen);

	assign in_stall  = state_q != StIdle;
	assign out_valid = state_q == StDone;
	assign pc_start  = state_q == StDup && at_end;

	// read address: next slot ahead of idx_q; shift reads downward
	always_comb begin
		rd_addr = idx_q[IdxW-1:0] + IdxW'(1);
		if (state_q == StIdle || state_q == StRdWait || state_q == StPop) begin
			rd_addr = '0;
		end else if (state_q == StShift) begin
			rd_addr = idx_q[IdxW-1:0] - IdxW'(2);
		end else if (state_q == StPos && (at_end || ins_before)) begin
			// prime the first shift step with the last occupied slot
			rd_addr = count_q[IdxW-1:0] - IdxW'(1);
		end
		wr_en   = 1'b0;
		wr_addr = idx_q[IdxW-1:0];
		wr_data = rd_s1;
		unique case (state_q)
			StShift: begin
				wr_en   = idx_q > wp_q;
				wr_addr = idx_q[IdxW-1:0];
			end
			StInsert: begin
				wr_en   = 1'b1;
				wr_addr = wp_q[IdxW-1:0];
				wr_data = new_q;
			end
			StRemove: begin
				wr_en   = !at_end && !filt;
				wr_addr = wp_q[IdxW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			count_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (in_valid) state_q <= StRdWait;
				StRdWait: begin
					unique case (func_q)
						iprt_pkg::FuncMatch:  state_q <= StMatch;
						iprt_pkg::FuncAdd:    state_q <= StDup;
						iprt_pkg::FuncRemove: state_q <= StRemove;
						default:              state_q <= StDone;
					endcase
				end
				StMatch: if (at_end || dst_q == iprt_pkg::LoopbackAddr
					|| rd_s1.host == dst_q || rd_s1.bcast == dst_q
					|| rd_s1.net == (dst_q & rd_s1.mask)) state_q <= StDone;
				StDup: begin
					if (count_q == CntW'(iprt_pkg::TableDepth)) state_q <= StDone;
					else if (!at_end && filt) state_q <= StDone;
					else if (at_end) state_q <= StPop;
				end
				StPop: if (pc_done) state_q <= StPos;
				StPos: if (at_end || ins_before) state_q <= StShift;
				StShift: if (idx_q <= wp_q) state_q <= StInsert;
				StInsert: begin
					count_q <= count_q + CntW'(1);
					state_q <= StDone;
				end
				StRemove: if (at_end) begin
					count_q <= wp_q;
					state_q <= StDone;
				end
				StDone: if (!out_stall) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				func_q        <= func;
				dst_q         <= dest_addr;
				new_q.net     <= route_net;
				new_q.mask    <= route_mask;
				new_q.host    <= route_host;
				new_q.gw      <= route_hop;
				new_q.bcast   <= route_broad;
				new_q.prio    <= route_prio;
				new_q.port    <= iface_id;
				new_q.plen    <= 6'd0;
				sel_q         <= compare_select;
				idx_q         <= '0;
				wp_q          <= '0;
				res_q         <= '0;
			end
			StRdWait: begin
				if (func_q == iprt_pkg::FuncMatch && dst_q == iprt_pkg::AnyAddr)
					res_q.addr_class <= iprt_pkg::ClassAny;
			end
			StMatch: begin
				idx_q <= idx_q + CntW'(1);
				if (dst_q == iprt_pkg::LoopbackAddr || (!at_end && rd_s1.host == dst_q)) begin
					res_q.addr_class <= (dst_q == iprt_pkg::LoopbackAddr)
						? iprt_pkg::ClassLoop : iprt_pkg::ClassLocal;
					res_q.hit   <= loop_en_q;
					res_q.iface <= loop_en_q ? loop_if_q : 4'd0;
					res_q.host  <= loop_en_q ? iprt_pkg::LoopbackAddr : 32'd0;
				end else if (!at_end && (rd_s1.bcast == dst_q
					|| rd_s1.net == (dst_q & rd_s1.mask))) begin
					if (rd_s1.bcast == dst_q) res_q.addr_class <= iprt_pkg::ClassBcast;
					else if (dst_q != iprt_pkg::AnyAddr)
						res_q.addr_class <= iprt_pkg::ClassSubnet;
					res_q.hit   <= 1'b1;
					res_q.iface <= rd_s1.port;
					res_q.host  <= rd_s1.host;
					res_q.hop   <= rd_s1.gw;
				end
			end
			StDup: begin
				if (count_q == CntW'(iprt_pkg::TableDepth))
					res_q.status <= iprt_pkg::StatusFull;
				else if (!at_end && filt) res_q.status <= iprt_pkg::StatusDup;
				if (at_end) idx_q <= '0;
				else idx_q <= idx_q + CntW'(1);
			end
			StPop: if (pc_done) new_q.plen <= pc_count;
			StPos: begin
				if (at_end || ins_before) begin
					wp_q  <= idx_q;
					idx_q <= count_q;
				end else begin
					idx_q <= idx_q + CntW'(1);
				end
			end
			StShift: idx_q <= idx_q - CntW'(1);
			StRemove: begin
				idx_q <= idx_q + CntW'(1);
				if (!at_end) begin
					if (filt) res_q.removed <= res_q.removed + 5'd1;
					else wp_q <= wp_q + CntW'(1);
				end
			end
			default: ;
		endcase
	end

	assign status        = res_q.status;
	assign addr_class    = res_q.addr_class;
	assign hit           = res_q.hit;
	assign out_iface     = res_q.iface;
	assign out_host      = res_q.host;
	assign out_hop       = res_q.hop;
	assign removed_count = res_q.removed;

endmodule

>>> rtl/core/iprt_checker.sv
// ----------------------------------------------------------------------------
// iprt_checker: port-level checks of the route table
// Watches the handshakes and result fields.
// ----------------------------------------------------------------------------
module iprt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [3:0]  out_iface,
	input logic [1:0]  status,
	input logic [2:0]  addr_class
);

	a_busy_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit))
		else $error("stalled result changed");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> out_iface == 4'd0) else $error("iface without hit");

	a_add_no_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != iprt_pkg::StatusOk
		|-> addr_class == iprt_pkg::ClassUnknown)
		else $error("class on add result");

endmodule

bind ipv4_route_table_classify iprt_checker u_iprt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.out_iface  (out_iface),
	.status     (status),
	.addr_class (addr_class)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: route table lookup, add and remove check
// Drives match, add and remove operations with random pacing. Each result is
// compared against an in-bench route table that tracks the expected contents.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] FuncUnused = 2'd3;

	typedef struct {
		logic [1:0]  fn;
		logic [31:0] dst;
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] host;
		logic [31:0] hop;
		logic [31:0] broad;
		logic [7:0]  prio;
		logic [3:0]  port;
		logic [3:0]  sel;
	} op_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid = 1'b0;
	logic        in_stall, out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  func = '0;
	logic [1:0]  status;
	logic [31:0] dest_addr = '0, route_net = '0, route_mask = '0;
	logic [31:0] route_host = '0, route_hop = '0, route_broad = '0;
	logic [7:0]  route_prio = '0;
	logic [3:0]  iface_id = '0, compare_select = '0;
	logic [3:0]  out_iface;
	logic [2:0]  addr_class;
	logic        hit;
	logic [31:0] out_host, out_hop;
	logic [4:0]  removed_count;

	ipv4_route_table_classify uut (.*);

	// shadow route table
	iprt_pkg::entry_t rt [iprt_pkg::TableDepth];
	int        rt_count = 0;
	logic      lp_en;
	logic [3:0] lp_if;

	op_t                pending_ops[$];
	iprt_pkg::result_t  expected_results[$];
	int        errors = 0, cfg_errors;
	int        n_match = 0, n_add = 0, n_remove = 0, n_hit = 0;
	int        in_gap = 0, out_gap = 0, idle_cycles = 0;
	int        n_in_acc = 0, n_in_sent = 0, n_out_acc = 0, n_out_seen = 0;
	bit        done;

	function automatic bit filter_hit(int i, op_t o);
		if (o.sel[0] && rt[i].port != o.port) return 0;
		if (o.sel[1] && rt[i].net != o.net) return 0;
		if (o.sel[2] && rt[i].host != o.host) return 0;
		if (o.sel[3] && rt[i].gw != o.hop) return 0;
		return 1;
	endfunction

	function automatic iprt_pkg::result_t route_apply(op_t o);
		iprt_pkg::result_t r;
		bit      use_loop;
		int      found, pos, w, len;
		r = '0;
		use_loop = 0;
		found = -1;
		if (o.fn == iprt_pkg::FuncMatch) begin
			n_match++;
			if (o.dst == iprt_pkg::AnyAddr) r.addr_class = iprt_pkg::ClassAny;
			if (o.dst == iprt_pkg::LoopbackAddr) begin
				r.addr_class = iprt_pkg::ClassLoop;
				use_loop = 1;
			end else begin
				for (int i = 0; i < rt_count; i++) begin
					if (rt[i].host == o.dst) begin
						r.addr_class = iprt_pkg::ClassLocal;
						use_loop = 1;
						break;
					end else if (rt[i].bcast == o.dst) begin
						r.addr_class = iprt_pkg::ClassBcast;
						found = i;
						break;
					end else if (rt[i].net == (o.dst & rt[i].mask)) begin
						if (o.dst != iprt_pkg::AnyAddr) r.addr_class = iprt_pkg::ClassSubnet;
						found = i;
						break;
					end
				end
			end
			if (use_loop) begin
				if (lp_en) begin
					r.hit = 1;
					r.iface = lp_if;
					r.host = iprt_pkg::LoopbackAddr;
				end
			end else if (found >= 0) begin
				r.hit = 1;
				r.iface = rt[found].port;
				r.host = rt[found].host;
				r.hop = rt[found].gw;
			end
			if (r.hit) n_hit++;
		end else if (o.fn == iprt_pkg::FuncAdd) begin
			n_add++;
			if (rt_count >= iprt_pkg::TableDepth) r.status = iprt_pkg::StatusFull;
			else begin
				for (int i = 0; i < rt_count; i++)
					if (filter_hit(i, o)) r.status = iprt_pkg::StatusDup;
				if (r.status == iprt_pkg::StatusOk) begin
					len = $countones(o.mask);
					pos = rt_count;
					for (int i = 0; i < rt_count; i++) begin
						if (o.prio > rt[i].prio
							|| (o.prio == rt[i].prio && len >= rt[i].plen)) begin
							pos = i;
							break;
						end
					end
					for (int i = rt_count; i > pos; i--) rt[i] = rt[i-1];
					rt[pos] = '{o.net, o.mask, o.host, o.hop, o.broad, o.prio, 6'(len),
						o.port};
					rt_count++;
				end
			end
		end else if (o.fn == iprt_pkg::FuncRemove) begin
			n_remove++;
			w = 0;
			for (int i = 0; i < rt_count; i++) begin
				if (filter_hit(i, o)) r.removed++;
				else begin
					rt[w] = rt[i];
					w++;
				end
			end
			rt_count = w;
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin : drive
		op_t o;
		int  g;
		if (arst_n) begin
			if (in_valid && n_in_acc != n_in_sent) begin
				// hold the payload until the transfer
			end else if (in_gap > 0) begin
				in_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (pending_ops.size() > 0) begin
				o = pending_ops.pop_front();
				expected_results.push_back(route_apply(o));
				in_valid <= 1;
				n_in_sent <= n_in_sent + 1;
				func <= o.fn; dest_addr <= o.dst; route_net <= o.net;
				route_mask <= o.mask; route_host <= o.host; route_hop <= o.hop;
				route_broad <= o.broad; route_prio <= o.prio;
				iface_id <= o.port; compare_select <= o.sel;
				in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			end else in_valid <= 0;
			if (n_out_acc != n_out_seen) begin
				n_out_seen <= n_out_acc;
				g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				out_stall <= g > 0;
				out_gap <= (g > 0) ? g - 1 : 0;
			end else if (out_gap > 0) begin
				out_stall <= 1;
				out_gap <= out_gap - 1;
			end else out_stall <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) n_in_acc <= n_in_acc + 1;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				n_out_acc <= n_out_acc + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d class=%0d", $time,
						status, addr_class);
					errors++;
				end else begin
					iprt_pkg::result_t e;
					iprt_pkg::result_t a;
					e = expected_results.pop_front();
					a = '{status, addr_class, hit, out_iface, out_host, out_hop, removed_count};
					if (a !== e) begin
						$display({"%0t: mismatch expected st=%0d cl=%0d hit=%0d if=%0d",
							" host=%h hop=%h rm=%0d"},
							$time, e.status, e.addr_class, e.hit, e.iface, e.host, e.hop,
							e.removed);
						$display({"%0t:          actual st=%0d cl=%0d hit=%0d if=%0d",
							" host=%h hop=%h rm=%0d"},
							$time, a.status, a.addr_class, a.hit, a.iface, a.host, a.hop,
							a.removed);
						errors++;
					end
				end
			end
			if (idle_cycles > 5000 && !done) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		logic [31:0] want;
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == {iprt_pkg::RegLoopEnable, 2'b00}) begin
			lp_en = val[0];
			want = {31'd0, val[0]};
		end else begin
			lp_if = val[3:0];
			want = {28'd0, val[3:0]};
		end
		#1;
		if (prdata !== want) begin
			$display("%0t: readback expected %h actual %h", $time, want, prdata);
			cfg_errors++;
		end
	endtask

	task automatic settle();
		while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 9))
			0: return iprt_pkg::AnyAddr;
			1: return iprt_pkg::LoopbackAddr;
			2: return 32'hFFFF_FFFF;
			3, 4, 5: if (rt_count > 0) begin
				int k;
				k = $urandom_range(0, rt_count - 1);
				case ($urandom_range(0, 2))
					0: return rt[k].host;
					1: return rt[k].bcast;
					default: return rt[k].net | ($urandom & ~rt[k].mask);
				endcase
			end else return $urandom;
			6: return {8'd10, 8'($urandom_range(0, 3)), 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t rand_op();
		op_t o;
		int  plen;
		plen = $urandom_range(0, 32);
		o.fn = ($urandom_range(0, 40) == 0) ? FuncUnused : 2'($urandom_range(0, 2));
		if (o.fn == iprt_pkg::FuncRemove && $urandom_range(0, 2) != 0)
			o.fn = iprt_pkg::FuncMatch;
		o.dst = pick_addr();
		o.mask = ($urandom_range(0, 7) == 0) ? $urandom : ~(32'hFFFF_FFFF >> plen);
		o.net = ($urandom_range(0, 3) == 0) ? $urandom
			: ({8'd10, 8'($urandom_range(0, 3)), 16'($urandom)} & o.mask);
		o.host = ($urandom_range(0, 3) == 0) ? $urandom : {8'd10, 24'($urandom)};
		o.hop = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
		o.broad = ($urandom_range(0, 2) == 0) ? 32'd0 : (o.net | ~o.mask);
		o.prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		o.port = 4'($urandom);
		o.sel = 4'($urandom);
		// reuse a stored route so filters hit
		if (rt_count > 0 && $urandom_range(0, 2) == 0) begin
			int k;
			k = $urandom_range(0, rt_count - 1);
			o.port = rt[k].port; o.net = rt[k].net; o.host = rt[k].host; o.hop = rt[k].gw;
		end
		return o;
	endfunction

	function automatic op_t mk(logic [1:0] fn, logic [31:0] dst, logic [31:0] net,
		logic [31:0] mask, logic [31:0] host, logic [31:0] hop, logic [31:0] broad,
		logic [7:0] prio, logic [3:0] port, logic [3:0] sel);
		return '{fn, dst, net, mask, host, hop, broad, prio, port, sel};
	endfunction

	function automatic op_t mk_match(logic [31:0] dst);
		return mk(iprt_pkg::FuncMatch, dst, '0, '0, '0, '0, '0, '0, '0, '0);
	endfunction

	initial begin
		op_t scratch;
		{psel, penable, pwrite, paddr, pwdata} = '0;
		cfg_errors = 0; done = 0;
		lp_en = 0; lp_if = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: empty table, then build it up
		pending_ops.push_back(mk_match(iprt_pkg::AnyAddr));
		pending_ops.push_back(mk_match(iprt_pkg::LoopbackAddr));
		pending_ops.push_back(mk(iprt_pkg::FuncRemove, '0, '0, '0, '0, '0, '0, '0, '0,
			4'hF));
		pending_ops.push_back(mk(FuncUnused, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'h0A00_0000, 32'hFF00_0000,
			32'h0A00_0001, 32'h0A00_00FE, 32'h0AFF_FFFF, 8'd0, 4'd1, 4'hF));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'h0A00_0000, 32'hFF00_0000,
			32'h0A00_0001, 32'h0A00_00FE, '0, 8'd5, 4'd1, 4'hF));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, '0, '0, '0, '0, '0, 8'hFF, 4'hF,
			4'h0));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, '0, '0, 32'hC0A8_0001, '0, '0,
			8'hFF, 4'hF, 4'h4));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1,
			'1, '1, 8'hFF, 4'hF, 4'hF));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'h5555_0000, 32'hF0F0_F0F0,
			32'h0B00_0001, '0, '0, 8'hFF, 4'h2, 4'h6));
		pending_ops.push_back(mk_match(iprt_pkg::AnyAddr));
		pending_ops.push_back(mk_match(iprt_pkg::LoopbackAddr));
		pending_ops.push_back(mk_match(32'h0A00_0001));
		pending_ops.push_back(mk_match(32'h0AFF_FFFF));
		pending_ops.push_back(mk_match(32'h0A12_3456));
		pending_ops.push_back(mk_match(32'hFFFF_FFFF));
		settle();
		reg_write({iprt_pkg::RegLoopEnable, 2'b00}, 32'd1);
		reg_write({iprt_pkg::RegLoopIface, 2'b00}, 32'd15);
		pending_ops.push_back(mk_match(iprt_pkg::LoopbackAddr));
		pending_ops.push_back(mk_match(32'h0A00_0001));
		pending_ops.push_back(mk_match(iprt_pkg::AnyAddr));
		// fill to full, then clear everything
		for (int i = 0; i < 14; i++)
			pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'(i), '1, 32'(i + 100), '0,
				'0, 8'(i), 4'(i), 4'h2));
		pending_ops.push_back(mk(iprt_pkg::FuncAdd, '0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
			8'd1, 4'd1, 4'h0));
		pending_ops.push_back(mk(iprt_pkg::FuncRemove, '0, '0, '0, '0, '0, '0, '0, '0,
			4'h0));
		settle();

		// random phases with several loopback settings
		for (int ph = 0; ph < 6; ph++) begin
			reg_write({iprt_pkg::RegLoopEnable, 2'b00}, ph % 2 == 1 ? '1 : 32'd0);
			reg_write({iprt_pkg::RegLoopIface, 2'b00}, ph == 0 ? 32'd0 : $urandom);
			for (int n = 0; n < 200; n++) begin
				// mimic the shadow table by predicting as the driver pops
				scratch = rand_op();
				pending_ops.push_back(scratch);
				while (pending_ops.size() > 4) @(posedge clk);
			end
			settle();
		end
		done = 1;
		$display("tb: %0d matches (%0d hits), %0d adds, %0d removes checked",
			n_match, n_hit, n_add, n_remove);
		if (errors == 0 && cfg_errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

endmodule
